@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the highway LSTM cell update block.
// Clocked, reset-qualified and plain clocked forms; empty under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define HLC_ASSERT_RST(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);
`define HLC_ASSERT_CLK(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HLC_ASSERT_RST(label, clk, rst_n, prop, msg)
`define HLC_ASSERT_CLK(label, clk, prop, msg)
`endif
`endif

@@ rtl/hlc_pkg.sv @@
// Package for the highway LSTM cell update: gate codes, Q16.16 constants,
// the shared multiplier request type, rounding/saturation and table helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hlc_pkg;

	localparam int HLC_DATA_WIDTH = 32;
	localparam int HLC_ACT_DEPTH  = 256;
	localparam int HLC_ACT_W      = 17;
	localparam int HLC_MUL_W      = 33;
	localparam int HLC_QS_W       = 50;
	localparam int HLC_SUM_W      = 51;
	localparam int HLC_Q_ONE      = 65536;

	localparam longint HLC_TANH_SPAN = 524288;
	localparam longint HLC_Q30_ONE   = 64'sd1073741824;
	localparam longint HLC_TAYLOR_DIV [1:14] = '{1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14};

	localparam logic [2:0] HLC_GATE_INPUT  = 3'd0;
	localparam logic [2:0] HLC_GATE_FORGET = 3'd1;
	localparam logic [2:0] HLC_GATE_CAND   = 3'd2;
	localparam logic [2:0] HLC_GATE_OUTPUT = 3'd3;
	localparam logic [2:0] HLC_GATE_CARRY  = 3'd4;
	localparam logic [2:0] HLC_GATE_FINISH = 3'd5;

	localparam logic signed [HLC_SUM_W-1:0] HLC_SAT_HI =
		HLC_SUM_W'((64'sd1 <<< (HLC_DATA_WIDTH - 1)) - 64'sd1);
	localparam logic signed [HLC_SUM_W-1:0] HLC_SAT_LO =
		HLC_SUM_W'(-(64'sd1 <<< (HLC_DATA_WIDTH - 1)));

	typedef struct packed {
		logic                        en;
		logic signed [HLC_MUL_W-1:0] a;
		logic signed [HLC_MUL_W-1:0] b;
	} hlc_mul_req_t;

	// Q16.16 product rounding: (p + 0.5) floored
	function automatic logic signed [HLC_QS_W-1:0] hlc_qs(input logic signed [2*HLC_MUL_W-1:0] p);
		logic signed [2*HLC_MUL_W-1:0] t;
		t = p + (2*HLC_MUL_W)'(32768);
		return t[2*HLC_MUL_W-1:16];
	endfunction

	function automatic logic signed [HLC_DATA_WIDTH-1:0] hlc_sat(
		input logic signed [HLC_SUM_W-1:0] v);
		logic signed [HLC_DATA_WIDTH-1:0] r;
		if (v > HLC_SAT_HI)
			r = HLC_SAT_HI[HLC_DATA_WIDTH-1:0];
		else if (v < HLC_SAT_LO)
			r = HLC_SAT_LO[HLC_DATA_WIDTH-1:0];
		else
			r = v[HLC_DATA_WIDTH-1:0];
		return r;
	endfunction

	// exp(-y) in Q30 for y in Q16.16 up to 16.0; elaboration use only
	function automatic longint hlc_exp_neg_q30(input longint y);
		longint term;
		longint sum;
		longint unsigned s;
		term = HLC_Q30_ONE;
		sum  = HLC_Q30_ONE;
		for (int k = 1; k <= 14; k++) begin
			term = ((term * y) >>> 20) / HLC_TAYLOR_DIV[k];
			if ((k & 1) != 0)
				sum = sum - term;
			else
				sum = sum + term;
		end
		if (sum < 0)
			sum = 0;
		if (sum > HLC_Q30_ONE)
			sum = HLC_Q30_ONE;
		s = longint'(sum);
		for (int n = 0; n < 4; n++)
			s = (s * s) >> 30;
		return longint'(s);
	endfunction

endpackage

`default_nettype wire

@@ rtl/hlc_if.sv @@
// Stream interfaces of the highway LSTM cell update: gate beats in, cell
// results out. Valid/ready handshake. Depends on hlc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface hlc_gate_if import hlc_pkg::*; ;
	logic                             valid;
	logic                             ready;
	logic [2:0]                       gate_index;
	logic signed [HLC_DATA_WIDTH-1:0] proj_in;
	logic signed [HLC_DATA_WIDTH-1:0] proj_rec;
	logic signed [HLC_DATA_WIDTH-1:0] bias_term;
	logic signed [HLC_DATA_WIDTH-1:0] cell_prev;
	logic signed [HLC_DATA_WIDTH-1:0] dropout_scale;

	modport source (output valid, gate_index, proj_in, proj_rec, bias_term, cell_prev,
		dropout_scale, input ready);
	modport sink (input valid, gate_index, proj_in, proj_rec, bias_term, cell_prev,
		dropout_scale, output ready);
endinterface

interface hlc_cell_if import hlc_pkg::*; ;
	logic                             valid;
	logic                             ready;
	logic signed [HLC_DATA_WIDTH-1:0] cell_next;
	logic signed [HLC_DATA_WIDTH-1:0] hidden_next;

	modport source (output valid, cell_next, hidden_next, input ready);
	modport sink (input valid, cell_next, hidden_next, output ready);
endinterface

`default_nettype wire

@@ rtl/hlc_tanh_rom.sv @@
// Tanh table over 0..8.0, DEPTH+1 entries in unsigned Q1.16, registered read.
// Entries are built at elaboration. Depends on hlc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hlc_tanh_rom import hlc_pkg::*; #(
	parameter int DEPTH = HLC_ACT_DEPTH
) (
	input  wire logic                         clk,
	input  wire logic [$clog2(DEPTH+1)-1:0]   addr,
	output logic      [HLC_ACT_W-1:0]         data_q
);

	logic [HLC_ACT_W-1:0] entry_w [DEPTH+1];

	for (genvar gk = 0; gk <= DEPTH; gk++) begin : g_entry
		localparam longint ARG  = (longint'(gk) * HLC_TANH_SPAN) / DEPTH;
		localparam longint EXPV = hlc_exp_neg_q30(2 * ARG);
		localparam longint DEN  = HLC_Q30_ONE + EXPV;
		localparam longint ENT  =
			((HLC_Q30_ONE - EXPV) * longint'(HLC_Q_ONE) + DEN / 2) / DEN;
		assign entry_w[gk] = HLC_ACT_W'(ENT);
	end

	always_ff @(posedge clk) begin
		data_q <= entry_w[addr];
	end

endmodule

`default_nettype wire

@@ rtl/hlc_mul_unit.sv @@
// Shared signed 33x33 multiplier with registered product.
// Driven by a request struct from the sequencer. Depends on hlc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hlc_mul_unit import hlc_pkg::*; (
	input  wire logic                            clk,
	input  wire hlc_mul_req_t                    req,
	output logic signed [2*HLC_MUL_W-1:0]        prod_q
);

	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_q <= req.a * req.b;
		end
	end

endmodule

`default_nettype wire

@@ rtl/highway_lstm_cell_update_top.sv @@
// Highway LSTM cell update: gate sum store, activation sequencer and output
// register. Uses hlc_pkg, hlc_if, hlc_mul_unit, hlc_tanh_rom, assert_macros.svh.
//
//  channel  dir  beat payload
//  in_ch    in   gate_index, proj_in, proj_rec, bias_term, cell_prev, dropout_scale
//  out_ch   out  cell_next, hidden_next
//
// Gate beats 0 to 4 are accepted back to back while idle; index 6 and 7 beats are dropped.
// A finish beat starts a sequence to its result: six table lookups, each with an
// index and an interpolation product, and six gate products share one multiplier
// and one table port, in sequence; a lookup past the table end skips the table reads
// and the interpolation product. in_ch.ready is low for the whole finish sequence.
// A result waits in the output register; the next beats are taken meanwhile.
// arst_n clears the sequencer, the output valid and the gate sums.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module highway_lstm_cell_update_top import hlc_pkg::*; #(
	parameter int ACT_TABLE_DEPTH = HLC_ACT_DEPTH
) (
	input wire logic   clk,
	input wire logic   arst_n,
	hlc_gate_if.sink   in_ch,
	hlc_cell_if.source out_ch
);

	localparam int AW = $clog2(ACT_TABLE_DEPTH + 1);

	typedef enum logic [17:0] {
		ST_IDLE     = 18'h00001,
		ST_ACT_ARG  = 18'h00002,
		ST_ACT_MUL  = 18'h00004,
		ST_ACT_IDX  = 18'h00008,
		ST_ACT_RD1  = 18'h00010,
		ST_ACT_RD2  = 18'h00020,
		ST_ACT_IMUL = 18'h00040,
		ST_ACT_FIN  = 18'h00080,
		ST_C_MUL1   = 18'h00100,
		ST_C_MUL2   = 18'h00200,
		ST_C_SUM    = 18'h00400,
		ST_H_MUL    = 18'h00800,
		ST_H_Q      = 18'h01000,
		ST_M_MUL1   = 18'h02000,
		ST_M_MUL2   = 18'h04000,
		ST_M_SUM    = 18'h08000,
		ST_D_MUL    = 18'h10000,
		ST_EMIT     = 18'h20000
	} hlc_state_t;

	hlc_state_t state_q;
	logic       out_valid_q;
	logic [2:0] act_idx_q;

	logic signed [HLC_DATA_WIDTH-1:0] gs_q [5];
	logic signed [HLC_DATA_WIDTH-1:0] pin_q, cprev_q, drop_q;
	logic signed [HLC_DATA_WIDTH-1:0] c_q, m_q, cell_q, hid_q;
	logic signed [17:0]               act_q [6];
	logic signed [17:0]               h_q;
	logic signed [34:0]               acc_q;
	logic [HLC_DATA_WIDTH-1:0]        mag_q;
	logic                             neg_q;
	logic                             sat_q;
	logic [AW-1:0]                    k_q;
	logic [18:0]                      f_q;
	logic [HLC_ACT_W-1:0]             lo_q;
	logic signed [18:0]               diff_q;

	logic                             in_acc;
	logic                             gate_is_sum;
	logic                             out_load;
	logic signed [33:0]               gsum;
	logic signed [HLC_DATA_WIDTH-1:0] x_sel;
	logic [HLC_DATA_WIDTH-1:0]        x_abs;
	logic [HLC_DATA_WIDTH-1:0]        mag_w;
	logic                             tanh_mode;
	logic                             idx_sat;
	logic signed [37:0]               ip_adj;
	logic signed [18:0]               iq;
	logic signed [18:0]               t_mag;
	logic signed [18:0]               t_sgn;
	logic signed [18:0]               t_sig;
	logic signed [17:0]               act_val;
	logic [AW-1:0]                    rom_addr;
	logic [HLC_ACT_W-1:0]             rom_data;
	hlc_mul_req_t                     mul_req;
	logic signed [2*HLC_MUL_W-1:0]    prod_q;

	hlc_mul_unit u_mul (
		.clk    (clk),
		.req    (mul_req),
		.prod_q (prod_q)
	);

	hlc_tanh_rom #(
		.DEPTH (ACT_TABLE_DEPTH)
	) u_rom (
		.clk    (clk),
		.addr   (rom_addr),
		.data_q (rom_data)
	);

	assign in_ch.ready        = (state_q == ST_IDLE);
	assign in_acc             = in_ch.valid && in_ch.ready;
	assign out_ch.valid       = out_valid_q;
	assign out_ch.cell_next   = cell_q;
	assign out_ch.hidden_next = hid_q;
	assign out_load           = !out_valid_q || out_ch.ready;

	assign gsum = {{2{in_ch.proj_in[HLC_DATA_WIDTH-1]}}, in_ch.proj_in}
		+ {{2{in_ch.proj_rec[HLC_DATA_WIDTH-1]}}, in_ch.proj_rec}
		+ {{2{in_ch.bias_term[HLC_DATA_WIDTH-1]}}, in_ch.bias_term};

	always_comb begin
		gate_is_sum = in_ch.gate_index inside {[HLC_GATE_INPUT:HLC_GATE_CARRY]};
	end

	// activation argument: |x|, halved for the sigmoid gates
	always_comb begin
		tanh_mode = (act_idx_q == HLC_GATE_CAND) || (act_idx_q == HLC_GATE_FINISH);
		case (act_idx_q)
			HLC_GATE_FINISH: x_sel = c_q;
			default:         x_sel = gs_q[act_idx_q];
		endcase
		x_abs = x_sel[HLC_DATA_WIDTH-1] ? HLC_DATA_WIDTH'(-x_sel) : HLC_DATA_WIDTH'(x_sel);
		mag_w = tanh_mode ? x_abs : (x_abs >> 1);
	end

	assign idx_sat = (prod_q[2*HLC_MUL_W-2:19] >= (2*HLC_MUL_W-20)'(ACT_TABLE_DEPTH));

	always_comb begin
		case (state_q)
			ST_ACT_IDX: rom_addr = prod_q[19 +: AW];
			default:    rom_addr = k_q + AW'(1);
		endcase
	end

	// interpolation, truncated toward zero, then sign and sigmoid fold
	always_comb begin
		ip_adj  = prod_q[37:0] + (prod_q[37] ? 38'sd524287 : 38'sd0);
		iq      = 19'(ip_adj >>> 19);
		t_mag   = sat_q ? 19'(HLC_Q_ONE) : ($signed({2'b00, lo_q}) + iq);
		t_sgn   = neg_q ? -t_mag : t_mag;
		t_sig   = (t_sgn + 19'(HLC_Q_ONE)) >>> 1;
		act_val = tanh_mode ? 18'(t_sgn) : 18'(t_sig);
	end

	always_comb begin
		mul_req.en = 1'b0;
		mul_req.a  = '0;
		mul_req.b  = '0;
		case (state_q)
			ST_ACT_MUL: begin
				mul_req.en = 1'b1;
				mul_req.a  = $signed({1'b0, mag_q});
				mul_req.b  = HLC_MUL_W'(ACT_TABLE_DEPTH);
			end
			ST_ACT_IMUL: begin
				mul_req.en = 1'b1;
				mul_req.a  = HLC_MUL_W'(diff_q);
				mul_req.b  = $signed({14'd0, f_q});
			end
			ST_C_MUL1: begin
				mul_req.en = 1'b1;
				mul_req.a  = HLC_MUL_W'(act_q[HLC_GATE_FORGET]);
				mul_req.b  = HLC_MUL_W'(cprev_q);
			end
			ST_C_MUL2: begin
				mul_req.en = 1'b1;
				mul_req.a  = HLC_MUL_W'(act_q[HLC_GATE_INPUT]);
				mul_req.b  = HLC_MUL_W'(act_q[HLC_GATE_CAND]);
			end
			ST_H_MUL: begin
				mul_req.en = 1'b1;
				mul_req.a  = HLC_MUL_W'(act_q[HLC_GATE_OUTPUT]);
				mul_req.b  = HLC_MUL_W'(act_q[HLC_GATE_FINISH]);
			end
			ST_M_MUL1: begin
				mul_req.en = 1'b1;
				mul_req.a  = HLC_MUL_W'(h_q);
				mul_req.b  = HLC_MUL_W'(act_q[HLC_GATE_CARRY]);
			end
			ST_M_MUL2: begin
				mul_req.en = 1'b1;
				mul_req.a  = HLC_MUL_W'(HLC_Q_ONE) - HLC_MUL_W'(act_q[HLC_GATE_CARRY]);
				mul_req.b  = HLC_MUL_W'(pin_q);
			end
			ST_D_MUL: begin
				mul_req.en = 1'b1;
				mul_req.a  = HLC_MUL_W'(m_q);
				mul_req.b  = HLC_MUL_W'(drop_q);
			end
			default: ;
		endcase
	end

	// sequencer, output valid, gate sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			act_idx_q   <= HLC_GATE_INPUT;
			for (int i = 0; i < 5; i++)
				gs_q[i] <= '0;
		end else begin
			if (in_acc && gate_is_sum)
				gs_q[in_ch.gate_index] <= hlc_sat(HLC_SUM_W'(gsum));
			if (state_q == ST_EMIT && out_load)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc && in_ch.gate_index == HLC_GATE_FINISH) begin
						act_idx_q <= HLC_GATE_INPUT;
						state_q   <= ST_ACT_ARG;
					end
				end
				ST_ACT_ARG:  state_q <= ST_ACT_MUL;
				ST_ACT_MUL:  state_q <= ST_ACT_IDX;
				ST_ACT_IDX:  state_q <= idx_sat ? ST_ACT_FIN : ST_ACT_RD1;
				ST_ACT_RD1:  state_q <= ST_ACT_RD2;
				ST_ACT_RD2:  state_q <= ST_ACT_IMUL;
				ST_ACT_IMUL: state_q <= ST_ACT_FIN;
				ST_ACT_FIN: begin
					case (act_idx_q)
						HLC_GATE_CARRY:  state_q <= ST_C_MUL1;
						HLC_GATE_FINISH: state_q <= ST_H_MUL;
						default: begin
							act_idx_q <= act_idx_q + 3'd1;
							state_q   <= ST_ACT_ARG;
						end
					endcase
				end
				ST_C_MUL1: state_q <= ST_C_MUL2;
				ST_C_MUL2: state_q <= ST_C_SUM;
				ST_C_SUM: begin
					act_idx_q <= HLC_GATE_FINISH;
					state_q   <= ST_ACT_ARG;
				end
				ST_H_MUL:  state_q <= ST_H_Q;
				ST_H_Q:    state_q <= ST_M_MUL1;
				ST_M_MUL1: state_q <= ST_M_MUL2;
				ST_M_MUL2: state_q <= ST_M_SUM;
				ST_M_SUM:  state_q <= ST_D_MUL;
				ST_D_MUL:  state_q <= ST_EMIT;
				ST_EMIT: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc && in_ch.gate_index == HLC_GATE_FINISH) begin
			pin_q   <= in_ch.proj_in;
			cprev_q <= in_ch.cell_prev;
			drop_q  <= in_ch.dropout_scale;
		end
		case (state_q)
			ST_ACT_ARG: begin
				mag_q <= mag_w;
				neg_q <= x_sel[HLC_DATA_WIDTH-1];
			end
			ST_ACT_IDX: begin
				k_q   <= prod_q[19 +: AW];
				f_q   <= prod_q[18:0];
				sat_q <= idx_sat;
			end
			ST_ACT_RD1: lo_q <= rom_data;
			ST_ACT_RD2: diff_q <= $signed({2'b00, rom_data}) - $signed({2'b00, lo_q});
			ST_ACT_FIN: act_q[act_idx_q] <= act_val;
			ST_C_MUL2:  acc_q <= 35'(hlc_qs(prod_q));
			ST_C_SUM:   c_q <= hlc_sat(HLC_SUM_W'(acc_q) + HLC_SUM_W'(hlc_qs(prod_q)));
			ST_H_Q:     h_q <= 18'(hlc_qs(prod_q));
			ST_M_MUL2:  acc_q <= 35'(hlc_qs(prod_q));
			ST_M_SUM:   m_q <= hlc_sat(HLC_SUM_W'(acc_q) + HLC_SUM_W'(hlc_qs(prod_q)));
			ST_EMIT: begin
				if (out_load) begin
					cell_q <= c_q;
					hid_q  <= hlc_sat(HLC_SUM_W'(hlc_qs(prod_q)));
				end
			end
			default: ;
		endcase
	end

	`HLC_ASSERT_RST(a_out_from_emit, clk, arst_n, $rose(out_ch.valid) |-> $past(state_q == ST_EMIT), "result raised outside emit")
	`HLC_ASSERT_RST(a_finish_starts, clk, arst_n, (in_acc && in_ch.gate_index == HLC_GATE_FINISH) |=> (state_q == ST_ACT_ARG), "finish beat did not start sequence")
	`HLC_ASSERT_RST(a_rom_range, clk, arst_n, (state_q == ST_ACT_RD1) |-> (k_q < AW'(ACT_TABLE_DEPTH)), "table index past last segment")
	`HLC_ASSERT_RST(a_sums_hold, clk, arst_n, (state_q != ST_IDLE) |=> $stable({gs_q[0], gs_q[1], gs_q[2], gs_q[3], gs_q[4]}), "gate sums changed while busy")
	`HLC_ASSERT_CLK(a_reset_state, clk, !arst_n |-> (state_q == ST_IDLE && !out_ch.valid), "control not cleared in reset")

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for highway_lstm_cell_update_top: directed gate beats, then
// random LSTM units under three idle mixes. Expected cell/hidden values come from a
// Q16.16 predictor kept here. Depends on hlc_pkg, hlc_if and the RTL of the block.
`timescale 1ns / 1ps

module testbench import hlc_pkg::*; ;

	localparam int WD          = HLC_DATA_WIDTH;
	localparam int LUT_DEPTH   = HLC_ACT_DEPTH;
	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 64;
	localparam int PHASE_ITEMS = 270;

	localparam longint Q_ONE  = 65536;
	localparam longint SPAN   = 524288;
	localparam longint Q30    = 64'sd1073741824;
	localparam longint FX_MAX = 64'sd2147483647;
	localparam longint FX_MIN = -64'sd2147483648;

	localparam logic [2:0] GATE_SPARE_LO = 3'd6;
	localparam logic [2:0] GATE_SPARE_HI = 3'd7;

	localparam logic signed [WD-1:0] Q_MAX = 32'sh7FFFFFFF;
	localparam logic signed [WD-1:0] Q_MIN = 32'sh80000000;
	localparam logic signed [WD-1:0] ONE   = 32'sh00010000;

	typedef struct packed {
		logic [2:0]           gate_index;
		logic signed [WD-1:0] proj_in;
		logic signed [WD-1:0] proj_rec;
		logic signed [WD-1:0] bias_term;
		logic signed [WD-1:0] cell_prev;
		logic signed [WD-1:0] dropout_scale;
		bit                   typed;
		logic signed [WD-1:0] cell_exp;
		logic signed [WD-1:0] hidden_exp;
	} gate_row_t;

	typedef struct packed {
		logic signed [WD-1:0] cell_next;
		logic signed [WD-1:0] hidden_next;
	} cell_update_t;

	logic clk;
	logic arst_n;

	hlc_gate_if gate_ch();
	hlc_cell_if cell_ch();

	highway_lstm_cell_update_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (gate_ch),
		.out_ch (cell_ch)
	);

	longint       tanh_lut [0:LUT_DEPTH];
	longint       gate_acc [0:4];
	cell_update_t cell_updates_due [$];
	gate_row_t    directed_rows [0:21];

	int error_count   = 0;
	int result_count  = 0;
	int stall_cycles  = 0;
	int src_idle_pct  = 30;
	int sink_idle_pct = 59;
	bit hold_request  = 1'b0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ---------------- predictor ----------------

	function automatic longint sat_fx(input longint v);
		if (v > FX_MAX)
			return FX_MAX;
		if (v < FX_MIN)
			return FX_MIN;
		return v;
	endfunction

	function automatic longint mul_fx(input longint a, input longint b);
		return (a * b + 32768) >>> 16;
	endfunction

	// exp(-y) in Q30, y in Q16.16 up to 16.0 (read as Q20 of y/16)
	function automatic longint exp_neg_q30(input longint y);
		longint          term;
		longint          acc;
		longint unsigned sq;
		term = Q30;
		acc  = Q30;
		for (int k = 1; k <= 14; k++) begin
			term = (term * y) / (longint'(k) * 1048576);
			if (k % 2 == 1)
				acc = acc - term;
			else
				acc = acc + term;
		end
		if (acc < 0)
			acc = 0;
		if (acc > Q30)
			acc = Q30;
		sq = longint'(acc);
		repeat (4)
			sq = (sq * sq) >> 30;
		return longint'(sq);
	endfunction

	function automatic longint tanh_fx(input longint x);
		longint mag;
		longint pos;
		longint k;
		longint t;
		mag = (x < 0) ? -x : x;
		pos = mag * LUT_DEPTH;
		k   = pos / SPAN;
		if (k >= LUT_DEPTH)
			t = Q_ONE;
		else
			t = tanh_lut[k] + ((tanh_lut[k+1] - tanh_lut[k]) * (pos % SPAN)) / SPAN;
		return (x < 0) ? -t : t;
	endfunction

	function automatic longint sigmoid_fx(input longint x);
		return (Q_ONE + tanh_fx(x / 2)) / 2;
	endfunction

	// gate beats store their sum; the finish beat yields one cell update
	function automatic bit lstm_unit_step(input gate_row_t b, output cell_update_t upd);
		longint ig;
		longint fg;
		longint cg;
		longint og;
		longint rg;
		longint c;
		longint h;
		longint m;
		upd = '0;
		if (b.gate_index < HLC_GATE_FINISH) begin
			gate_acc[b.gate_index] = sat_fx(longint'(b.proj_in) + longint'(b.proj_rec)
				+ longint'(b.bias_term));
			return 1'b0;
		end
		if (b.gate_index != HLC_GATE_FINISH)
			return 1'b0;
		ig = sigmoid_fx(gate_acc[HLC_GATE_INPUT]);
		fg = sigmoid_fx(gate_acc[HLC_GATE_FORGET]);
		cg = tanh_fx(gate_acc[HLC_GATE_CAND]);
		og = sigmoid_fx(gate_acc[HLC_GATE_OUTPUT]);
		rg = sigmoid_fx(gate_acc[HLC_GATE_CARRY]);
		c = sat_fx(mul_fx(fg, b.cell_prev) + mul_fx(ig, cg));
		h = mul_fx(og, tanh_fx(c));
		m = sat_fx(mul_fx(h, rg) + mul_fx(Q_ONE - rg, b.proj_in));
		h = sat_fx(mul_fx(m, b.dropout_scale));
		upd.cell_next   = c[WD-1:0];
		upd.hidden_next = h[WD-1:0];
		return 1'b1;
	endfunction

	// ---------------- stimulus ----------------

	function automatic logic signed [WD-1:0] fx_near(input int unsigned span);
		case ($urandom_range(0, 15))
			0:       return Q_MAX;
			1:       return Q_MIN;
			2, 3:    return $urandom;
			default: return int'($urandom_range(0, 2 * span)) - int'(span);
		endcase
	endfunction

	function automatic gate_row_t make_gate_row(input logic [2:0] g);
		gate_row_t r;
		r = '{g, $urandom, $urandom, $urandom, $urandom, $urandom, 1'b0, 0, 0};
		if (g == HLC_GATE_FINISH) begin
			r.proj_in       = fx_near(4 << 16);
			r.cell_prev     = fx_near(6 << 16);
			r.dropout_scale = fx_near(3 << 16);
		end else if (g < HLC_GATE_FINISH) begin
			r.proj_in   = fx_near(3 << 16);
			r.proj_rec  = fx_near(3 << 16);
			r.bias_term = fx_near(3 << 16);
		end
		return r;
	endfunction

	task automatic drive_gate(input gate_row_t row);
		cell_update_t upd;
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			gate_ch.valid <= 1'b0;
			@(negedge clk);
		end
		gate_ch.valid         <= 1'b1;
		gate_ch.gate_index    <= row.gate_index;
		gate_ch.proj_in       <= row.proj_in;
		gate_ch.proj_rec      <= row.proj_rec;
		gate_ch.bias_term     <= row.bias_term;
		gate_ch.cell_prev     <= row.cell_prev;
		gate_ch.dropout_scale <= row.dropout_scale;
		do
			@(posedge clk);
		while (gate_ch.ready !== 1'b1);
		if (lstm_unit_step(row, upd)) begin
			if (row.typed)
				upd = '{row.cell_exp, row.hidden_exp};
			cell_updates_due.push_back(upd);
		end
	endtask

	// one unit: gates 0-4 with the odd skip, repeat or stray beat, then finish; or a lone random beat
	task automatic send_unit(inout int sent);
		gate_row_t noise;
		if ($urandom_range(0, 19) == 0) begin
			noise = '{3'($urandom_range(0, 7)), $urandom, $urandom, $urandom, $urandom,
				$urandom, 1'b0, 0, 0};
			drive_gate(noise);
			if (noise.gate_index <= HLC_GATE_FINISH)
				sent++;
			return;
		end
		for (int g = 0; g < 5; g++) begin
			if ($urandom_range(0, 14) != 0) begin
				drive_gate(make_gate_row(3'(g)));
				sent++;
			end
			if ($urandom_range(0, 14) == 0) begin
				drive_gate(make_gate_row(3'(g)));
				sent++;
			end
		end
		if ($urandom_range(0, 19) == 0)
			drive_gate(make_gate_row($urandom_range(0, 1) ? GATE_SPARE_HI : GATE_SPARE_LO));
		drive_gate(make_gate_row(HLC_GATE_FINISH));
		sent++;
	endtask

	task automatic drain_results();
		@(negedge clk);
		gate_ch.valid <= 1'b0;
		while (cell_updates_due.size() != 0)
			@(posedge clk);
	endtask

	// ---------------- checking ----------------

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH %s", $time, msg);
		error_count++;
	endtask

	always @(posedge clk) begin : check_results
		cell_update_t want;
		if (cell_ch.valid === 1'b1 && cell_ch.ready === 1'b1) begin
			result_count++;
			if (cell_updates_due.size() == 0) begin
				report_mismatch($sformatf("result %0d with nothing due: cell %h hidden %h",
					result_count, cell_ch.cell_next, cell_ch.hidden_next));
			end else begin
				want = cell_updates_due.pop_front();
				if (cell_ch.cell_next !== want.cell_next)
					report_mismatch($sformatf("result %0d cell_next got %h want %h",
						result_count, cell_ch.cell_next, want.cell_next));
				if (cell_ch.hidden_next !== want.hidden_next)
					report_mismatch($sformatf("result %0d hidden_next got %h want %h",
						result_count, cell_ch.hidden_next, want.hidden_next));
			end
		end
	end

	always @(posedge clk) begin
		if ((gate_ch.valid === 1'b1 && gate_ch.ready === 1'b1)
				|| (cell_ch.valid === 1'b1 && cell_ch.ready === 1'b1)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d results outstanding",
				stall_cycles, cell_updates_due.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// result side: random backpressure plus one long hold on request
	initial begin : sink_side
		int hold_left;
		hold_left     = 0;
		cell_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_left    = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				cell_ch.ready <= 1'b0;
			end else begin
				cell_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
			end
		end
	end

	initial begin : stimulus
		longint lut_x;
		longint lut_e;
		int     sent;
		bit     hold_done;
		arst_n                = 1'b1;
		gate_ch.valid         = 1'b0;
		gate_ch.gate_index    = HLC_GATE_INPUT;
		gate_ch.proj_in       = '0;
		gate_ch.proj_rec      = '0;
		gate_ch.bias_term     = '0;
		gate_ch.cell_prev     = '0;
		gate_ch.dropout_scale = '0;
		hold_done             = 1'b0;
		for (int k = 0; k <= LUT_DEPTH; k++) begin
			lut_x = (longint'(k) * SPAN) / LUT_DEPTH;
			lut_e = exp_neg_q30(2 * lut_x);
			tanh_lut[k] = ((Q30 - lut_e) * Q_ONE + (Q30 + lut_e) / 2) / (Q30 + lut_e);
		end
		for (int i = 0; i < 5; i++)
			gate_acc[i] = 0;

		// typed rows: all sums zero after reset; all gates saturated high; all low
		directed_rows = '{
			'{HLC_GATE_FINISH, 0, 0, 0, 0, Q_MAX, 1'b1, 0, 0},
			'{GATE_SPARE_LO, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, 1'b0, 0, 0},
			'{GATE_SPARE_HI, -1, -1, -1, -1, -1, 1'b0, 0, 0},
			'{HLC_GATE_INPUT, Q_MAX, Q_MAX, Q_MAX, 0, 0, 1'b0, 0, 0},
			'{HLC_GATE_FORGET, Q_MAX, Q_MAX, Q_MAX, 0, 0, 1'b0, 0, 0},
			'{HLC_GATE_CAND, Q_MAX, Q_MAX, Q_MAX, 0, 0, 1'b0, 0, 0},
			'{HLC_GATE_OUTPUT, Q_MAX, Q_MAX, Q_MAX, 0, 0, 1'b0, 0, 0},
			'{HLC_GATE_CARRY, Q_MAX, Q_MAX, Q_MAX, 0, 0, 1'b0, 0, 0},
			'{HLC_GATE_FINISH, 0, -1, -1, Q_MAX, Q_MIN, 1'b1, Q_MAX, Q_MIN},
			'{HLC_GATE_INPUT, Q_MIN, Q_MIN, Q_MIN, -1, -1, 1'b0, 0, 0},
			'{HLC_GATE_FORGET, Q_MIN, Q_MIN, Q_MIN, -1, -1, 1'b0, 0, 0},
			'{HLC_GATE_CAND, Q_MIN, Q_MIN, Q_MIN, -1, -1, 1'b0, 0, 0},
			'{HLC_GATE_OUTPUT, Q_MIN, Q_MIN, Q_MIN, -1, -1, 1'b0, 0, 0},
			'{HLC_GATE_CARRY, Q_MIN, Q_MIN, Q_MIN, -1, -1, 1'b0, 0, 0},
			'{HLC_GATE_FINISH, ONE, Q_MAX, Q_MAX, Q_MIN, Q_MAX, 1'b1, 0, Q_MAX},
			'{HLC_GATE_CAND, ONE, ONE, -ONE, 0, 0, 1'b0, 0, 0},
			'{HLC_GATE_CAND, 32'sh00004000, -32'sh00020000, 0, 0, 0, 1'b0, 0, 0},
			'{HLC_GATE_INPUT, 32'sh00008000, 0, 32'sh00001234, 0, 0, 1'b0, 0, 0},
			'{HLC_GATE_FINISH, 32'sh00018000, 0, 0, 32'sh00030000, 32'sh00020000,
				1'b0, 0, 0},
			'{HLC_GATE_FINISH, -ONE, 0, 0, -32'sh00050000, ONE, 1'b0, 0, 0},
			'{HLC_GATE_OUTPUT, 1, 2, -4, 0, 0, 1'b0, 0, 0},
			'{HLC_GATE_FINISH, 32'sh0000C000, 0, 0, 32'sh00007000, -ONE, 1'b0, 0, 0}
		};

		#1 arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < $size(directed_rows); i++)
			drive_gate(directed_rows[i]);

		for (int phase = 0; phase < 3; phase++) begin
			src_idle_pct  = (phase == 0) ? 30 : (phase == 1) ? 59 : 0;
			sink_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 30 : 0;
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if (phase == 2 && !hold_done && sent >= 90) begin
					hold_request = 1'b1;
					hold_done    = 1'b1;
				end
				send_unit(sent);
			end
			drain_results();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/hlc_pkg.sv
rtl/hlc_if.sv
rtl/hlc_tanh_rom.sv
rtl/hlc_mul_unit.sv
rtl/highway_lstm_cell_update_top.sv
tb/testbench.sv
